### rtl/mqf_pkg.sv
`timescale 1ns / 1ps

package mqf_pkg;

	// Default cap on the downstream buffer size.
	localparam int BUFFER_LIMIT_DEF = 256;

	// Configuration port geometry and register indexes.
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 9;
	localparam logic [CFG_INDEX_W-1:0] REG_BUFFER_SIZE   = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_STREAM_ENABLE = 2'd1;

	// Reset value of the buffer size register.
	localparam logic [CFG_DATA_W-1:0] BUFFER_SIZE_RESET = 9'd256;

	// Packet type of a publish, from the upper nibble of the header byte.
	localparam logic [3:0] TYPE_PUBLISH = 4'd3;

	// One result item, one per received byte.
	typedef struct packed {
		logic [7:0] byte_out;
		logic       store_valid;
		logic [7:0] store_addr;
		logic       stream_valid;
		logic       packet_done;
		logic       malformed;
		logic [3:0] packet_type;
		logic [2:0] length_bytes;
		logic [8:0] kept_length;
	} mqf_result_t;

endpackage

### rtl/mqf_channels.sv
`timescale 1ns / 1ps

// Received byte channel.
interface mqf_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

// Framed result channel, one transfer per received byte.
interface mqf_result_if;
	logic       valid;
	logic       ready;
	logic [7:0] byte_out;
	logic       store_valid;
	logic [7:0] store_addr;
	logic       stream_valid;
	logic       packet_done;
	logic       malformed;
	logic [3:0] packet_type;
	logic [2:0] length_bytes;
	logic [8:0] kept_length;

	modport source (
		output valid, output byte_out, output store_valid, output store_addr,
		output stream_valid, output packet_done, output malformed,
		output packet_type, output length_bytes, output kept_length,
		input ready
	);
	modport sink (
		input valid, input byte_out, input store_valid, input store_addr,
		input stream_valid, input packet_done, input malformed,
		input packet_type, input length_bytes, input kept_length,
		output ready
	);
endinterface

### rtl/mqf_core.sv
`timescale 1ns / 1ps

module mqf_core import mqf_pkg::*; #(
	parameter int BUFFER_LIMIT = BUFFER_LIMIT_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	input  logic                   accept,
	input  logic [7:0]             rx_byte,
	output mqf_result_t            result
);

	localparam logic [2:0] PH_HEADER   = 3'd0;
	localparam logic [2:0] PH_LENGTH   = 3'd1;
	localparam logic [2:0] PH_TOPIC_HI = 3'd2;
	localparam logic [2:0] PH_TOPIC_LO = 3'd3;
	localparam logic [2:0] PH_BODY     = 3'd4;

	localparam logic [2:0] MAX_DIGITS   = 3'd4;

	// Store addresses never go past 256, whatever the limit.
	localparam int CAP = (BUFFER_LIMIT < 256) ? BUFFER_LIMIT : 256;
	localparam logic [8:0] SIZE_CAP = 9'(CAP);

	logic [8:0]  buffer_size_q;
	logic        stream_enable_q;

	logic [2:0]  phase_q, phase_d;
	logic [27:0] rem_len_q, rem_len_d;
	logic [2:0]  digit_q, digit_d;
	logic        publish_q, publish_d;
	logic        qos_one_q, qos_one_d;
	logic [7:0]  topic_hi_q, topic_hi_d;
	logic [16:0] skip_q, skip_d;
	logic [27:0] body_q, body_d;
	logic [28:0] total_q, total_inc;
	logic [8:0]  stored_q, stored_inc;
	logic [3:0]  type_q, type_d;

	logic [8:0]  eff_size;
	logic        is_header;
	logic [8:0]  stored_base;
	logic [28:0] total_base;
	logic        take;
	logic [8:0]  kept_fin;
	logic        fin;
	logic        bad_len;
	logic [27:0] digit_val;
	logic [27:0] rem_sum;
	logic [2:0]  digit_inc;
	logic [27:0] body_inc;
	logic [28:0] lead;

	// Configuration registers; the user must write them only while the framer is idle, the block does not enforce it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buffer_size_q   <= BUFFER_SIZE_RESET;
			stream_enable_q <= 1'b0;
		end else if (cfg_we) begin
			if (cfg_index == REG_BUFFER_SIZE) begin
				buffer_size_q <= cfg_data;
			end else if (cfg_index == REG_STREAM_ENABLE) begin
				stream_enable_q <= cfg_data[0];
			end
		end
	end

	assign eff_size = (buffer_size_q > SIZE_CAP) ? SIZE_CAP : buffer_size_q;

	// Buffer address and byte counting shared by every phase.
	always_comb begin
		is_header   = !(phase_q == PH_LENGTH || phase_q == PH_TOPIC_HI ||
			phase_q == PH_TOPIC_LO || phase_q == PH_BODY);
		stored_base = is_header ? 9'd0 : stored_q;
		total_base  = is_header ? 29'd0 : total_q;
		take        = stored_base < eff_size;
		stored_inc  = take ? stored_base + 9'd1 : stored_base;
		total_inc   = total_base + 29'd1;
		// A packet that overflowed the buffer is dropped unless streaming is enabled.
		kept_fin    = (!stream_enable_q && total_inc > {20'd0, eff_size}) ? 9'd0 : stored_inc;
	end

	// Length digit weight: the digits fill 7-bit groups low first.
	always_comb begin
		case (digit_q[1:0])
			2'd0:    digit_val = {21'd0, rx_byte[6:0]};
			2'd1:    digit_val = {14'd0, rx_byte[6:0], 7'd0};
			2'd2:    digit_val = {7'd0, rx_byte[6:0], 14'd0};
			default: digit_val = {rx_byte[6:0], 21'd0};
		endcase
		rem_sum   = rem_len_q + digit_val;
		digit_inc = digit_q + 3'd1;
		body_inc  = body_q + 28'd1;
		lead      = {26'd0, digit_q} + 29'd2;
	end

	// Phase update and result assembly for one received byte.
	always_comb begin
		phase_d    = phase_q;
		rem_len_d  = rem_len_q;
		digit_d    = digit_q;
		publish_d  = publish_q;
		qos_one_d  = qos_one_q;
		topic_hi_d = topic_hi_q;
		skip_d     = skip_q;
		body_d     = body_q;
		type_d     = type_q;
		fin        = 1'b0;
		bad_len    = 1'b0;

		result             = '0;
		result.byte_out    = rx_byte;
		result.store_valid = take;
		result.store_addr  = take ? stored_base[7:0] : 8'd0;

		case (phase_q)
			PH_LENGTH: begin
				rem_len_d = rem_sum;
				digit_d   = digit_inc;
				if (rx_byte[7]) begin
					if (digit_inc >= MAX_DIGITS) begin
						fin     = 1'b1;
						bad_len = 1'b1;
					end
				end else if (publish_q) begin
					phase_d = PH_TOPIC_HI;
				end else if (rem_sum == 28'd0) begin
					fin = 1'b1;
				end else begin
					body_d  = 28'd0;
					phase_d = PH_BODY;
				end
			end
			PH_TOPIC_HI: begin
				topic_hi_d = rx_byte;
				phase_d    = PH_TOPIC_LO;
			end
			PH_TOPIC_LO: begin
				skip_d = {1'b0, topic_hi_q, rx_byte} + (qos_one_q ? 17'd2 : 17'd0);
				body_d = 28'd2;
				if (rem_len_q <= 28'd2) begin
					fin = 1'b1;
				end else begin
					phase_d = PH_BODY;
				end
			end
			PH_BODY: begin
				// Payload starts after the length field, topic and message id.
				result.stream_valid = stream_enable_q && publish_q && total_q >= lead &&
					(total_q - lead) > {12'd0, skip_q};
				body_d = body_inc;
				if (body_inc >= rem_len_q) begin
					fin = 1'b1;
				end
			end
			default: begin
				type_d     = rx_byte[7:4];
				publish_d  = (rx_byte[7:4] == TYPE_PUBLISH);
				qos_one_d  = rx_byte[1];
				rem_len_d  = 28'd0;
				digit_d    = 3'd0;
				skip_d     = 17'd0;
				body_d     = 28'd0;
				topic_hi_d = 8'd0;
				phase_d    = PH_LENGTH;
			end
		endcase

		if (fin) begin
			result.packet_done  = 1'b1;
			result.malformed    = bad_len;
			result.packet_type  = type_q;
			result.length_bytes = digit_d;
			result.kept_length  = bad_len ? 9'd0 : kept_fin;
			phase_d             = PH_HEADER;
		end
	end

	// Framer state advances on every accepted byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_HEADER;
			rem_len_q  <= '0;
			digit_q    <= '0;
			publish_q  <= 1'b0;
			qos_one_q  <= 1'b0;
			topic_hi_q <= '0;
			skip_q     <= '0;
			body_q     <= '0;
			total_q    <= '0;
			stored_q   <= '0;
			type_q     <= '0;
		end else if (accept) begin
			phase_q    <= phase_d;
			rem_len_q  <= rem_len_d;
			digit_q    <= digit_d;
			publish_q  <= publish_d;
			qos_one_q  <= qos_one_d;
			topic_hi_q <= topic_hi_d;
			skip_q     <= skip_d;
			body_q     <= body_d;
			total_q    <= total_inc;
			stored_q   <= stored_inc;
			type_q     <= type_d;
		end
	end

	// A malformed length always closes the packet with four digits and nothing kept.
	a_malformed_closes: assert property (@(posedge clk) disable iff (!arst_n)
		accept && result.malformed |->
			result.packet_done && result.length_bytes == MAX_DIGITS &&
			result.kept_length == 9'd0)
		else $error("malformed result without a clean close");

	// Store addresses stay inside the effective buffer.
	a_store_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		accept && result.store_valid |-> {1'b0, result.store_addr} < eff_size)
		else $error("store address beyond buffer size");

	// A finished packet sends the framer back to the header phase.
	a_done_to_header: assert property (@(posedge clk) disable iff (!arst_n)
		accept && result.packet_done |=> phase_q == PH_HEADER)
		else $error("framer did not return to header after packet end");

	// A header byte restarts the count and moves on to the length field.
	a_header_restart: assert property (@(posedge clk) disable iff (!arst_n)
		accept && phase_q == PH_HEADER |=> phase_q == PH_LENGTH && total_q == 29'd1)
		else $error("header byte did not restart the packet");

endmodule

### rtl/mqf_out_reg.sv
`timescale 1ns / 1ps

module mqf_out_reg import mqf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        load,
	input  mqf_result_t data,
	output logic        space,
	output logic        valid,
	input  logic        ready,
	output mqf_result_t q
);

	logic        valid_q;
	mqf_result_t data_q;

	// A new result may enter when the register is empty or being drained.
	assign space = !valid_q || ready;
	assign valid = valid_q;
	assign q     = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (ready) begin
			valid_q <= 1'b0;
		end
	end

	// Payload holds until the next load.
	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= data;
		end
	end

endmodule

### rtl/mqtt_packet_receive_framer.sv
`timescale 1ns / 1ps

// Channel   Role    Payload
// rx        sink    rx_byte
// result    source  byte_out, store_valid, store_addr, stream_valid, packet_done,
//                   malformed, packet_type, length_bytes, kept_length
// cfg       write   cfg_we, cfg_index, cfg_data (buffer_size, stream_enable)
//
// One byte is accepted per clock; its result appears in the output register in the cycle after.
// The rate is set by the single framing step between the byte input and the output register.
// Reset clears the phase, counters and output valid; configuration resets to size 256, no stream.
// While a result is stalled the input is held off; the next byte is taken in the cycle
// that the held result transfers.
module mqtt_packet_receive_framer import mqf_pkg::*; #(
	parameter int BUFFER_LIMIT = BUFFER_LIMIT_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	mqf_byte_if.sink               rx,
	mqf_result_if.source           result,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	logic        accept;
	logic        space;
	mqf_result_t core_res;
	mqf_result_t out_res;

	// A byte transfer happens whenever a byte is offered and the output register has room.
	assign rx.ready = space;
	assign accept   = rx.valid && space;

	mqf_core #(
		.BUFFER_LIMIT(BUFFER_LIMIT)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.accept   (accept),
		.rx_byte  (rx.rx_byte),
		.result   (core_res)
	);

	mqf_out_reg u_out (
		.clk   (clk),
		.arst_n(arst_n),
		.load  (accept),
		.data  (core_res),
		.space (space),
		.valid (result.valid),
		.ready (result.ready),
		.q     (out_res)
	);

	// Result fields onto the output channel.
	assign result.byte_out     = out_res.byte_out;
	assign result.store_valid  = out_res.store_valid;
	assign result.store_addr   = out_res.store_addr;
	assign result.stream_valid = out_res.stream_valid;
	assign result.packet_done  = out_res.packet_done;
	assign result.malformed    = out_res.malformed;
	assign result.packet_type  = out_res.packet_type;
	assign result.length_bytes = out_res.length_bytes;
	assign result.kept_length  = out_res.kept_length;

endmodule

### sim/mqf_framer_checker.sv
`timescale 1ns / 1ps

// Watches the byte and result channels, frames every accepted byte the way the
// block should, and compares each result transfer with the oldest framed byte.
module mqf_framer_checker import mqf_pkg::*; #(
	parameter int BUFFER_LIMIT = BUFFER_LIMIT_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	mqf_byte_if                    rx,
	mqf_result_if                  result,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	output int                     errors,
	output int                     pending
);

	typedef enum logic [2:0] {
		PH_HEADER,
		PH_LENGTH,
		PH_TOPIC_HI,
		PH_TOPIC_LO,
		PH_BODY
	} frame_phase_e;

	// Copy of the configuration registers.
	logic [8:0]   cfg_size;
	logic         cfg_stream;

	// Copy of the framing state.
	frame_phase_e ph;
	logic [27:0]  rem_len;
	logic [2:0]   digits;
	logic         is_pub;
	logic         qos1;
	logic [7:0]   topic_hi;
	logic [16:0]  skip;
	logic [27:0]  body_cnt;
	logic [28:0]  total_cnt;
	logic [8:0]   stored_cnt;
	logic [3:0]   hdr_type;

	// Results of the bytes that were accepted but not yet seen on the output.
	mqf_result_t  framed_q[$];

	// Buffer size in effect, limited by the parameter and by the address range.
	function automatic logic [8:0] buf_capacity();
		logic [8:0] s;
		s = cfg_size;
		if (s > BUFFER_LIMIT)
			s = 9'(BUFFER_LIMIT);
		if (s > 9'd256)
			s = 9'd256;
		return s;
	endfunction

	// Give the byte the next buffer address while there is room, and count it.
	task automatic store_byte(inout mqf_result_t r);
		if (stored_cnt < buf_capacity()) begin
			r.store_valid = 1'b1;
			r.store_addr  = stored_cnt[7:0];
			stored_cnt    = stored_cnt + 9'd1;
		end
		total_cnt = total_cnt + 29'd1;
	endtask

	// Report the end of the packet and go back to waiting for a header.
	task automatic close_packet(inout mqf_result_t r);
		r.packet_done  = 1'b1;
		r.packet_type  = hdr_type;
		r.length_bytes = digits;
		if (!cfg_stream && total_cnt > buf_capacity())
			r.kept_length = 9'd0;
		else
			r.kept_length = stored_cnt;
		ph = PH_HEADER;
	endtask

	// Frame one received byte and work out its result.
	task automatic frame_byte(input logic [7:0] b, output mqf_result_t r);
		r = '0;
		r.byte_out = b;
		case (ph)
			PH_LENGTH: begin
				store_byte(r);
				rem_len = rem_len + (28'(b[6:0]) << (7 * digits[1:0]));
				digits  = digits + 3'd1;
				if (b[7]) begin
					// A fourth digit that still continues ends the packet as malformed.
					if (digits >= 3'd4) begin
						close_packet(r);
						r.malformed   = 1'b1;
						r.kept_length = 9'd0;
					end
				end else if (is_pub) begin
					ph = PH_TOPIC_HI;
				end else if (rem_len == 28'd0) begin
					close_packet(r);
				end else begin
					body_cnt = 28'd0;
					ph       = PH_BODY;
				end
			end
			PH_TOPIC_HI: begin
				store_byte(r);
				topic_hi = b;
				ph       = PH_TOPIC_LO;
			end
			PH_TOPIC_LO: begin
				store_byte(r);
				skip     = {1'b0, topic_hi, b} + (qos1 ? 17'd2 : 17'd0);
				body_cnt = 28'd2;
				// A publish this short ends on its second topic-length byte.
				if (rem_len <= 28'd2)
					close_packet(r);
				else
					ph = PH_BODY;
			end
			PH_BODY: begin
				// Payload past the topic and message id goes to the stream.
				if (cfg_stream && is_pub &&
						32'(total_cnt) >= 32'(digits) + 2 &&
						32'(total_cnt) - 32'(digits) - 2 > 32'(skip))
					r.stream_valid = 1'b1;
				store_byte(r);
				body_cnt = body_cnt + 28'd1;
				if (body_cnt >= rem_len)
					close_packet(r);
			end
			default: begin
				total_cnt  = '0;
				stored_cnt = '0;
				store_byte(r);
				hdr_type = b[7:4];
				is_pub   = (b[7:4] == TYPE_PUBLISH);
				qos1     = b[1];
				rem_len  = '0;
				digits   = '0;
				skip     = '0;
				body_cnt = '0;
				topic_hi = '0;
				ph       = PH_LENGTH;
			end
		endcase
	endtask

	// Compare one field and report it when it differs.
	task automatic check_field(input string name, input logic [8:0] want_v,
			input logic [8:0] got_v);
		if (want_v !== got_v) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want_v, got_v);
			errors++;
		end
	endtask

	// Track configuration writes, frame byte transfers and check result transfers.
	always @(posedge clk or negedge arst_n) begin
		mqf_result_t want;
		mqf_result_t got;
		if (!arst_n) begin
			cfg_size   = BUFFER_SIZE_RESET;
			cfg_stream = 1'b0;
			ph         = PH_HEADER;
			rem_len    = '0;
			digits     = '0;
			is_pub     = 1'b0;
			qos1       = 1'b0;
			topic_hi   = '0;
			skip       = '0;
			body_cnt   = '0;
			total_cnt  = '0;
			stored_cnt = '0;
			hdr_type   = '0;
			framed_q.delete();
			errors     = 0;
			pending    = 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_BUFFER_SIZE)
					cfg_size = cfg_data;
				else if (cfg_index == REG_STREAM_ENABLE)
					cfg_stream = cfg_data[0];
			end
			if (rx.valid && rx.ready) begin
				frame_byte(rx.rx_byte, want);
				framed_q.push_back(want);
			end
			if (result.valid && result.ready) begin
				got = {result.byte_out, result.store_valid, result.store_addr,
					result.stream_valid, result.packet_done, result.malformed,
					result.packet_type, result.length_bytes, result.kept_length};
				if (framed_q.size() == 0) begin
					$display("%0t: result transfer with none expected, expected nothing, actual %h",
						$time, got);
					errors++;
				end else begin
					want = framed_q.pop_front();
					check_field("byte_out", 9'(want.byte_out), 9'(got.byte_out));
					check_field("store_valid", 9'(want.store_valid), 9'(got.store_valid));
					check_field("store_addr", 9'(want.store_addr), 9'(got.store_addr));
					check_field("stream_valid", 9'(want.stream_valid), 9'(got.stream_valid));
					check_field("packet_done", 9'(want.packet_done), 9'(got.packet_done));
					check_field("malformed", 9'(want.malformed), 9'(got.malformed));
					check_field("packet_type", 9'(want.packet_type), 9'(got.packet_type));
					check_field("length_bytes", 9'(want.length_bytes), 9'(got.length_bytes));
					check_field("kept_length", want.kept_length, got.kept_length);
				end
			end
			pending = framed_q.size();
		end
	end

endmodule

### sim/tb_mqtt_packet_receive_framer.sv
`timescale 1ns / 1ps

module tb_mqtt_packet_receive_framer;
	import mqf_pkg::*;

	localparam logic [3:0] TYPE_PINGREQ = 4'd12;
	localparam int PHASE_ITEMS  = 220;
	localparam int NUM_PHASES   = 5;
	localparam int IDLE_PERCENT = 23;
	localparam int HOLD_CYCLES  = 300;
	localparam int QUIET_LIMIT  = 5000;
	localparam int DRAIN_CYCLES = 8;

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;
	int                     errors;
	int                     pending;
	bit                     idle_on = 1'b1;
	bit                     hold_req = 1'b0;
	bit                     hold_ack = 1'b0;
	int                     hold_left = 0;
	int                     quiet_cycles = 0;
	int unsigned            items_sent = 0;
	logic [7:0]             pkt_q[$];

	mqf_byte_if   rx_ch();
	mqf_result_if res_ch();

	mqtt_packet_receive_framer uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.rx        (rx_ch),
		.result    (res_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	mqf_framer_checker frame_chk (
		.clk       (clk),
		.arst_n    (arst_n),
		.rx        (rx_ch),
		.result    (res_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.errors    (errors),
		.pending   (pending)
	);

	// Clock, 10 ns period.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Result receiver: random stalls, plus a long hold-off on request.
	// A request is a toggle of hold_req that this process acknowledges.
	always @(negedge clk) begin
		if (hold_req != hold_ack) begin
			hold_left = HOLD_CYCLES;
			hold_ack  = hold_req;
		end
		if (hold_left > 0) begin
			hold_left--;
			res_ch.ready <= 1'b0;
		end else begin
			res_ch.ready <= !(idle_on && $urandom_range(99) < IDLE_PERCENT);
		end
	end

	// Watchdog on cycles without any transfer.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((rx_ch.valid && rx_ch.ready) || (res_ch.valid && res_ch.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	// Offer one byte, with random gaps, and wait for its transfer.
	task automatic send_byte(input logic [7:0] b);
		@(negedge clk);
		while (idle_on && $urandom_range(99) < IDLE_PERCENT) begin
			rx_ch.valid <= 1'b0;
			@(negedge clk);
		end
		rx_ch.valid   <= 1'b1;
		rx_ch.rx_byte <= b;
		@(posedge clk);
		while (!rx_ch.ready)
			@(posedge clk);
		items_sent++;
	endtask

	// Send every byte waiting in the packet queue.
	task automatic send_queue();
		while (pkt_q.size() > 0)
			send_byte(pkt_q.pop_front());
	endtask

	// Stop offering bytes and wait until every result has come back.
	task automatic rx_quiet();
		@(negedge clk);
		rx_ch.valid <= 1'b0;
		wait (pending == 0);
	endtask

	// Write one configuration register while the block is idle.
	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		rx_quiet();
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(negedge clk);
		cfg_we    <= 1'b0;
	endtask

	// Body length: mostly short, sometimes long enough to overflow the buffer.
	function automatic int unsigned pick_length();
		if ($urandom_range(99) < 4)
			return $urandom_range(240, 300);
		return $urandom_range(20);
	endfunction

	// Any packet type except publish.
	function automatic logic [3:0] non_publish_type();
		logic [3:0] t;
		t = 4'($urandom_range(15));
		if (t == TYPE_PUBLISH)
			t = TYPE_PINGREQ;
		return t;
	endfunction

	// Queue a packet: header, length digits (sometimes padded to more digits
	// than needed), topic length for a publish, then random body bytes.
	task automatic queue_packet(input logic [7:0] hdr, input int unsigned len,
			input logic [15:0] topic_len);
		int unsigned ndig;
		int unsigned min_dig;
		int unsigned nbody;
		int unsigned i;
		min_dig = (len < 128) ? 1 : (len < 16384) ? 2 : 3;
		ndig    = min_dig;
		if ($urandom_range(99) < 20)
			ndig = $urandom_range(min_dig, 4);
		pkt_q.push_back(hdr);
		for (i = 0; i < ndig; i++)
			pkt_q.push_back({(i + 1 < ndig), 7'((len >> (7 * i)) & 127)});
		nbody = len;
		if (hdr[7:4] == TYPE_PUBLISH) begin
			pkt_q.push_back(topic_len[15:8]);
			pkt_q.push_back(topic_len[7:0]);
			nbody = (len > 2) ? len - 2 : 0;
		end
		for (i = 0; i < nbody; i++)
			pkt_q.push_back(8'($urandom_range(255)));
	endtask

	// Stimulus: directed packets first, then random phases of packets.
	initial begin
		int unsigned      target;
		int unsigned      pick;
		int unsigned      len;
		int unsigned      i;
		int               ph;
		bit               paused;
		logic [7:0]       hdr;
		logic [15:0]      topic_len;
		logic [8:0]       size;
		logic             stream;

		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_index     = '0;
		cfg_data      = '0;
		rx_ch.valid   = 1'b0;
		rx_ch.rx_byte = '0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		// Zero-length ping, malformed length with all-ones digits, short QoS1
		// publish, publish with topic and message id, four-digit zero length.
		pkt_q = '{8'hC0, 8'h00,
			8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
			8'h3F, 8'h01, 8'hFF, 8'hFF,
			8'h32, 8'h05, 8'h00, 8'h01, 8'h41, 8'h00, 8'h07,
			8'hE0, 8'h80, 8'h80, 8'h80, 8'h00};
		send_queue();

		for (ph = 0; ph < NUM_PHASES; ph++) begin
			case (ph)
				0: begin
					size   = 9'd256;
					stream = 1'b1;
				end
				1: begin
					size   = 9'd8;
					stream = 1'b0;
				end
				2: begin
					size   = 9'd8;
					stream = 1'b1;
				end
				3: begin
					size   = 9'd256;
					stream = 1'b0;
				end
				default: begin
					size   = 9'($urandom_range(8, 256));
					stream = 1'($urandom_range(1));
				end
			endcase
			write_reg(REG_BUFFER_SIZE, size);
			write_reg(REG_STREAM_ENABLE, {8'd0, stream});
			idle_on = (ph != 3);
			paused  = 1'b0;
			// Let the result side back up while bytes keep coming.
			if (ph == 1)
				hold_req = !hold_req;
			target = items_sent + PHASE_ITEMS;
			while (items_sent < target) begin
				pick = $urandom_range(99);
				if (pick < 10) begin
					// Malformed length: four digits that all continue.
					pkt_q.push_back(8'($urandom_range(255)));
					for (i = 0; i < 4; i++)
						pkt_q.push_back({1'b1, 7'($urandom_range(127))});
				end else if (pick < 20) begin
					queue_packet({non_publish_type(), 4'($urandom_range(15))}, 0, 16'd0);
				end else if (pick < 60) begin
					hdr = {TYPE_PUBLISH, 4'($urandom_range(15))};
					if ($urandom_range(9) == 0)
						topic_len = 16'($urandom_range(65535));
					else
						topic_len = 16'($urandom_range(8));
					if ($urandom_range(19) == 0)
						len = $urandom_range(2);
					else
						len = 2 + ((topic_len < 16) ? topic_len : $urandom_range(8)) +
							(hdr[1] ? 2 : 0) + pick_length();
					queue_packet(hdr, len, topic_len);
				end else begin
					queue_packet({non_publish_type(), 4'($urandom_range(15))},
						pick_length(), 16'd0);
				end
				send_queue();
				// Halfway through one phase, wait for the block to drain.
				if (ph == 2 && !paused && items_sent + PHASE_ITEMS / 2 > target) begin
					rx_quiet();
					paused = 1'b1;
				end
			end
		end

		rx_quiet();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
